// ===== design/prst_pkg.sv =====
// Shared types and constants for the periodic report scheduler table.
package prst_pkg;

  localparam int PRST_SLOTS      = 16;
  localparam int PRST_MAX_PARAMS = 16;

  typedef enum logic [2:0] {
    REQ_DEFINE  = 3'd0,
    REQ_DELETE  = 3'd1,
    REQ_ENABLE  = 3'd2,
    REQ_DISABLE = 3'd3,
    REQ_REPORT  = 3'd4,
    REQ_TICK    = 3'd5
  } req_type_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_BAD_PARAM = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    KIND_REPLY  = 1'b0,
    KIND_REPORT = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CHECK,
    S_REPLY,
    S_FLUSH
  } state_t;

  // One table entry as held in the slot RAM
  typedef struct packed {
    logic [15:0] id;
    logic [15:0] period;
    logic [31:0] last_time;
  } slot_entry_t;

  // Per-slot evaluation from the shared compare unit
  typedef struct packed {
    logic match;
    logic free;
    logic due;
  } slot_eval_t;

endpackage

// ===== design/prst_if.sv =====
// Request and response channel interfaces.
interface prst_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [15:0] struct_id;
  logic [15:0] period;
  logic [7:0]  param_count;
  logic [31:0] now_ms;

  modport source (output valid, req_type, struct_id, period, param_count, now_ms,
                  input ready);
  modport sink (input valid, req_type, struct_id, period, param_count, now_ms,
                output ready);
endinterface

interface prst_rsp_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [1:0]  status;
  logic [15:0] report_id;
  logic        last;

  modport source (output valid, kind, status, report_id, last, input ready);
  modport sink (input valid, kind, status, report_id, last, output ready);
endinterface

// ===== design/prst_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module prst_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]     wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== design/prst_eval.sv =====
// Shared slot compare unit: id match, free slot and due-time check.
module prst_eval import prst_pkg::*; (
  input  logic        slot_valid,
  input  logic        slot_enabled,
  input  slot_entry_t entry,
  input  logic [15:0] struct_id,
  input  logic [31:0] now_ms,
  output slot_eval_t  ev
);

  logic [31:0] elapsed;

  // Wrapped elapsed time since the entry last fired
  assign elapsed = now_ms - entry.last_time;

  always_comb begin
    ev.match = slot_valid && (entry.id == struct_id);
    ev.free  = !slot_valid;
    ev.due   = slot_valid && slot_enabled && (entry.period != 16'd0) &&
               (elapsed >= {16'd0, entry.period});
  end

endmodule

// ===== design/periodic_report_scheduler_table.sv =====
// Top level of the periodic report scheduler table.
//
// Requests arrive on the req channel (valid/ready); one transfer carries a
// define, delete, enable, disable, report-now or tick request. Results leave
// on the rsp channel (valid/ready) with a last flag on the final result of
// a request. Commands give exactly one result; a tick gives one report per
// due entry in slot order, or none.
// The block takes one request at a time. The slot table sits in a RAM with
// a registered read, and one compare unit visits the slots one at a time,
// each through a read state and a check state, so a request holds the block
// until its scan and its result are done: a command stops at the first
// matching slot, a command with no match and a tick walk all SLOTS slots.
// Requests with a bad parameter count or an unknown type skip the scan and
// go straight to the reply state.
// A single output register holds a finished result; while the receiver
// stalls it, the scan waits at the next due entry and no request is taken.
// Synchronous reset clears all valid and enabled marks and the channels;
// no clearing pass over the RAM is needed.
module periodic_report_scheduler_table import prst_pkg::*; #(
  parameter int SLOTS      = PRST_SLOTS,
  parameter int MAX_PARAMS = PRST_MAX_PARAMS
) (
  input  logic      clk,
  input  logic      rst,
  prst_req_if.sink  req,
  prst_rsp_if.source rsp
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  state_t state, state_next;

  // Latched request
  req_type_t   rtype;
  logic [15:0] sid;
  logic [15:0] per;
  logic [31:0] now;
  logic        bad;

  // Scan state
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] hit_idx;
  logic [IDX_W-1:0] free_idx;
  logic             hit;
  logic             free_found;
  logic             held_v;
  logic [15:0]      held_id;

  // Table marks
  logic [SLOTS-1:0] valid;
  logic [SLOTS-1:0] enabled;

  // RAM and compare unit
  logic [$bits(slot_entry_t)-1:0] rd_raw;
  slot_entry_t      rd_entry;
  slot_entry_t      wr_entry;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  slot_eval_t       ev;

  // Output register
  logic        rsp_valid_q;
  kind_t       kind_q;
  status_t     status_q;
  logic [15:0] id_q;
  logic        last_q;

  // Control from the sequencer
  logic        acc;
  logic        bad_in;
  logic        is_tick;
  logic        out_free;
  logic        chk_end;
  logic        chk_stall;
  logic        out_load;
  kind_t       out_kind;
  status_t     out_status;
  logic [15:0] out_id;
  logic        out_last;
  logic        vb_set;
  logic        vb_clr;
  logic        en_set;
  logic        en_clr;
  logic [IDX_W-1:0] tgt_idx;

  prst_ram #(
    .WIDTH ($bits(slot_entry_t)),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_entry),
    .rd_addr (idx),
    .rd_data (rd_raw)
  );

  assign rd_entry = slot_entry_t'(rd_raw);

  prst_eval u_eval (
    .slot_valid   (valid[idx]),
    .slot_enabled (enabled[idx]),
    .entry        (rd_entry),
    .struct_id    (sid),
    .now_ms       (now),
    .ev           (ev)
  );

  // Handshake and status terms
  assign req.ready = (state == S_IDLE);
  assign acc       = req.valid && req.ready;
  assign bad_in    = ((req.req_type == REQ_DEFINE) &&
                      (req.param_count > 8'(MAX_PARAMS))) ||
                     (req.req_type > REQ_TICK);
  assign is_tick   = (rtype == REQ_TICK);
  assign out_free  = !rsp_valid_q || rsp.ready;
  assign chk_end   = (idx == LAST_IDX);
  assign chk_stall = is_tick && ev.due && held_v && !out_free;

  assign rsp.valid     = rsp_valid_q;
  assign rsp.kind      = kind_q;
  assign rsp.status    = status_q;
  assign rsp.report_id = id_q;
  assign rsp.last      = last_q;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (acc) begin
          state_next = bad_in ? S_REPLY : S_READ;
        end
      end
      S_READ: begin
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (is_tick) begin
          if (!chk_stall) begin
            state_next = chk_end ? S_FLUSH : S_READ;
          end
        end else if (ev.match || chk_end) begin
          state_next = S_REPLY;
        end else begin
          state_next = S_READ;
        end
      end
      S_REPLY: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      S_FLUSH: begin
        if (!held_v || out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Sequencer outputs: RAM writes, mark updates, result loads
  always_comb begin
    wr_en      = 1'b0;
    wr_addr    = idx;
    wr_entry   = '{id: rd_entry.id, period: rd_entry.period, last_time: now};
    out_load   = 1'b0;
    out_kind   = KIND_REPLY;
    out_status = STAT_OK;
    out_id     = sid;
    out_last   = 1'b1;
    vb_set     = 1'b0;
    vb_clr     = 1'b0;
    en_set     = 1'b0;
    en_clr     = 1'b0;
    tgt_idx    = hit_idx;
    unique case (state)
      S_CHECK: begin
        // Due entry: restamp it and pass on the previously held report
        if (is_tick && ev.due && !chk_stall) begin
          wr_en = 1'b1;
          if (held_v) begin
            out_load = 1'b1;
            out_kind = KIND_REPORT;
            out_id   = held_id;
            out_last = 1'b0;
          end
        end
      end
      S_REPLY: begin
        if (out_free) begin
          out_load = 1'b1;
          if (bad) begin
            out_status = STAT_BAD_PARAM;
          end else begin
            unique case (rtype)
              REQ_DEFINE: begin
                if (hit || free_found) begin
                  tgt_idx  = hit ? hit_idx : free_idx;
                  wr_en    = 1'b1;
                  wr_addr  = tgt_idx;
                  wr_entry = '{id: sid, period: per, last_time: 32'd0};
                  vb_set   = 1'b1;
                  en_clr   = 1'b1;
                end else begin
                  out_status = STAT_FULL;
                end
              end
              REQ_DELETE: begin
                vb_clr     = hit;
                out_status = hit ? STAT_OK : STAT_NOT_FOUND;
              end
              REQ_ENABLE: begin
                en_set     = hit;
                out_status = hit ? STAT_OK : STAT_NOT_FOUND;
              end
              REQ_DISABLE: begin
                en_clr     = hit;
                out_status = hit ? STAT_OK : STAT_NOT_FOUND;
              end
              REQ_REPORT: begin
                out_kind   = hit ? KIND_REPORT : KIND_REPLY;
                out_status = hit ? STAT_OK : STAT_NOT_FOUND;
              end
              default: begin
                out_status = STAT_BAD_PARAM;
              end
            endcase
          end
        end
      end
      S_FLUSH: begin
        // Final report of a tick carries last
        if (held_v && out_free) begin
          out_load = 1'b1;
          out_kind = KIND_REPORT;
          out_id   = held_id;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      held_v      <= 1'b0;
      valid       <= '0;
      enabled     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid_q <= 1'b0;
      end
      if (acc) begin
        held_v <= 1'b0;
      end else if (state == S_CHECK && is_tick && ev.due && !chk_stall) begin
        held_v <= 1'b1;
      end else if (state == S_FLUSH && out_free) begin
        held_v <= 1'b0;
      end
      if (vb_set) begin
        valid[tgt_idx] <= 1'b1;
      end
      if (vb_clr) begin
        valid[tgt_idx] <= 1'b0;
      end
      if (en_set) begin
        enabled[tgt_idx] <= 1'b1;
      end
      if (en_clr) begin
        enabled[tgt_idx] <= 1'b0;
      end
    end
  end

  // Payload and scan registers
  always_ff @(posedge clk) begin
    if (acc) begin
      rtype      <= req_type_t'(req.req_type);
      sid        <= req.struct_id;
      per        <= req.period;
      now        <= req.now_ms;
      bad        <= bad_in;
      idx        <= '0;
      hit        <= 1'b0;
      free_found <= 1'b0;
    end else if (state == S_CHECK) begin
      if (is_tick) begin
        if (!chk_stall) begin
          if (ev.due) begin
            held_id <= rd_entry.id;
          end
          if (!chk_end) begin
            idx <= idx + 1'b1;
          end
        end
      end else if (ev.match) begin
        hit     <= 1'b1;
        hit_idx <= idx;
      end else begin
        if (ev.free && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= idx;
        end
        if (!chk_end) begin
          idx <= idx + 1'b1;
        end
      end
    end
    if (out_load) begin
      kind_q   <= out_kind;
      status_q <= out_status;
      id_q     <= out_id;
      last_q   <= out_last;
    end
  end

  // Table RAM is written only while checking a tick slot or replying
  a_wr_phase: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> ((state == S_CHECK) && is_tick) || (state == S_REPLY))
    else $error("slot RAM write outside check or reply");

  // No report is held over once the block is idle
  a_held_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !held_v)
    else $error("held report left over at idle");

  // Command replies are always the final result of their request
  a_reply_last: assert property (@(posedge clk) disable iff (rst)
    (out_load && (out_kind == KIND_REPLY)) |-> out_last)
    else $error("command reply without last");

  // A result is never loaded over one the receiver has not taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> out_free)
    else $error("output register overwritten");

  // An accepted request starts a scan or goes straight to the reply state
  a_accept_next: assert property (@(posedge clk) disable iff (rst)
    acc |=> (state == S_READ) || (state == S_REPLY))
    else $error("bad state after request transfer");

endmodule

// ===== dv/periodic_report_scheduler_table_tb.sv =====
// Testbench for the periodic report scheduler table: directed and random requests checked against a table model.
module periodic_report_scheduler_table_tb;
  import prst_pkg::*;

  localparam logic [2:0] REQ_RSVD_6 = 3'd6;
  localparam logic [2:0] REQ_RSVD_7 = 3'd7;
  localparam int RANDOM_ITEMS  = 250;
  localparam int LONG_HOLD     = 300;
  localparam int QUIET_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 2 * PRST_SLOTS + 8;
  localparam int POOL_SIZE     = 20;

  typedef struct {
    logic [2:0]  code;
    logic [15:0] sid;
    logic [15:0] per;
    logic [7:0]  cnt;
    logic [31:0] now;
  } request_t;

  typedef struct {
    kind_t       kind;
    status_t     status;
    logic [15:0] rid;
    logic        last;
  } result_t;

  // Table model plus the queue of results the block still owes
  class sched_scoreboard;
    bit          used[PRST_SLOTS];
    bit          armed[PRST_SLOTS];
    logic [15:0] sid[PRST_SLOTS];
    logic [15:0] per[PRST_SLOTS];
    logic [31:0] stamp[PRST_SLOTS];
    result_t     owed_q[$];
    int          errors;

    function int pending();
      return owed_q.size();
    endfunction

    function int find_id(logic [15:0] id);
      for (int i = 0; i < PRST_SLOTS; i++)
        if (used[i] && sid[i] == id) return i;
      return -1;
    endfunction

    function void post(kind_t k, status_t st, logic [15:0] id, logic lst);
      result_t r;
      r.kind = k;
      r.status = st;
      r.rid = id;
      r.last = lst;
      owed_q.push_back(r);
    endfunction

    // Apply one accepted request to the table and queue what it emits
    function void take_request(request_t r);
      int s;
      int due[$];
      s = find_id(r.sid);
      case (r.code)
        REQ_DEFINE: begin
          if (r.cnt > PRST_MAX_PARAMS) begin
            post(KIND_REPLY, STAT_BAD_PARAM, r.sid, 1'b1);
          end else begin
            if (s < 0)
              for (int i = 0; i < PRST_SLOTS; i++)
                if (!used[i] && s < 0) s = i;
            if (s < 0) begin
              post(KIND_REPLY, STAT_FULL, r.sid, 1'b1);
            end else begin
              sid[s] = r.sid;
              per[s] = r.per;
              armed[s] = 1'b0;
              stamp[s] = '0;
              used[s] = 1'b1;
              post(KIND_REPLY, STAT_OK, r.sid, 1'b1);
            end
          end
        end
        REQ_DELETE, REQ_ENABLE, REQ_DISABLE: begin
          if (s < 0) begin
            post(KIND_REPLY, STAT_NOT_FOUND, r.sid, 1'b1);
          end else begin
            if (r.code == REQ_DELETE) used[s] = 1'b0;
            else armed[s] = (r.code == REQ_ENABLE);
            post(KIND_REPLY, STAT_OK, r.sid, 1'b1);
          end
        end
        REQ_REPORT: begin
          if (s < 0) post(KIND_REPLY, STAT_NOT_FOUND, r.sid, 1'b1);
          else post(KIND_REPORT, STAT_OK, r.sid, 1'b1);
        end
        REQ_TICK: begin
          // elapsed time wraps modulo 2^32
          for (int i = 0; i < PRST_SLOTS; i++)
            if (used[i] && armed[i] && per[i] != 16'd0 &&
                (r.now - stamp[i]) >= {16'd0, per[i]})
              due.push_back(i);
          foreach (due[k]) begin
            post(KIND_REPORT, STAT_OK, sid[due[k]], k == due.size() - 1);
            stamp[due[k]] = r.now;
          end
        end
        default: post(KIND_REPLY, STAT_BAD_PARAM, r.sid, 1'b1);
      endcase
    endfunction

    function void match_result(result_t got);
      result_t want;
      if (owed_q.size() == 0) begin
        $display("%0t unexpected result: kind=%0d status=%0d id=%h last=%0d",
                 $time, got.kind, got.status, got.rid, got.last);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      if (got.kind !== want.kind || got.status !== want.status ||
          got.rid !== want.rid || got.last !== want.last) begin
        $display("%0t mismatch: expected kind=%0d status=%0d id=%h last=%0d, got kind=%0d status=%0d id=%h last=%0d",
                 $time, want.kind, want.status, want.rid, want.last,
                 got.kind, got.status, got.rid, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  prst_req_if req_ch();
  prst_rsp_if rsp_ch();

  periodic_report_scheduler_table dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  sched_scoreboard sb = new();
  logic [15:0] id_pool[POOL_SIZE];
  logic [31:0] now_clock;
  int          sent_count;
  int          hold_asks;
  int          hold_seen;
  int          rx_hold;
  int          rx_stall;
  int          rx_cycle;
  logic        rx_next;
  result_t     rx_item;
  int          quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Idle lengths: mostly short, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(25, 60);
  endfunction

  function automatic request_t mk(logic [2:0] code, logic [15:0] id, logic [15:0] p,
                                  logic [7:0] c, logic [31:0] t);
    request_t r;
    r.code = code;
    r.sid = id;
    r.per = p;
    r.cnt = c;
    r.now = t;
    return r;
  endfunction

  // Random request: mostly well-formed traffic over a small id pool
  function automatic request_t draw_request();
    request_t r;
    int pick;
    r = mk(REQ_TICK, 16'($urandom), 16'($urandom), 8'($urandom), 32'($urandom));
    if ($urandom_range(0, 9) != 0) r.sid = id_pool[$urandom_range(0, POOL_SIZE - 1)];
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      r.code = REQ_DEFINE;
      case ($urandom_range(0, 9))
        0: r.per = 16'd0;
        1: r.per = 16'($urandom);
        default: r.per = 16'($urandom_range(1, 60));
      endcase
      if ($urandom_range(0, 7) != 0) r.cnt = 8'($urandom_range(0, PRST_MAX_PARAMS));
    end else if (pick < 45) begin
      r.code = REQ_ENABLE;
    end else if (pick < 52) begin
      r.code = REQ_DISABLE;
    end else if (pick < 60) begin
      r.code = REQ_DELETE;
    end else if (pick < 70) begin
      r.code = REQ_REPORT;
    end else if (pick < 97) begin
      r.code = REQ_TICK;
      case ($urandom_range(0, 29))
        0: now_clock = $urandom;
        1: now_clock = now_clock - 32'($urandom_range(0, 100));
        default: now_clock = now_clock + 32'($urandom_range(0, 40));
      endcase
      r.now = now_clock;
    end else begin
      r.code = ($urandom_range(0, 1) != 0) ? REQ_RSVD_6 : REQ_RSVD_7;
    end
    return r;
  endfunction

  // Offer one request and wait for its transfer
  task automatic send_request(request_t r);
    int gap;
    gap = ((sent_count % 60) < 12 || $urandom_range(0, 1) == 0) ? 0 : idle_len();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.req_type    <= r.code;
    req_ch.struct_id   <= r.sid;
    req_ch.period      <= r.per;
    req_ch.param_count <= r.cnt;
    req_ch.now_ms      <= r.now;
    @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);
    sb.take_request(r);
    sent_count++;
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Response side: random stalls, burst windows, and a long hold on request
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      rx_cycle++;
      if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
        rx_item.kind   = kind_t'(rsp_ch.kind);
        rx_item.status = status_t'(rsp_ch.status);
        rx_item.rid    = rsp_ch.report_id;
        rx_item.last   = rsp_ch.last;
        sb.match_result(rx_item);
      end
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        rx_hold = LONG_HOLD;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        rx_next = 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        rx_next = 1'b0;
      end else begin
        rx_next = 1'b1;
        if ((rx_cycle % 500) >= 100 && $urandom_range(0, 3) == 0) rx_stall = idle_len();
      end
      rsp_ch.ready <= rx_next;
    end
  end

  // Watchdog: too long without any transfer ends the run
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t no transfer for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, sb.pending());
      $display("[periodic_report_scheduler_table] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_DEFINE;
    req_ch.struct_id = '0;
    req_ch.period = '0;
    req_ch.param_count = '0;
    req_ch.now_ms = '0;
    rsp_ch.ready = 1'b0;
    sent_count = 0;
    hold_asks = 0;
    hold_seen = 0;
    rx_hold = 0;
    rx_stall = 0;
    rx_cycle = 0;
    quiet_cycles = 0;
    for (int i = 0; i < POOL_SIZE; i++) id_pool[i] = 16'($urandom);
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: field extremes, every request type, wrap and error cases
    send_request(mk(REQ_DEFINE,  16'h0000, 16'd1,     8'd0,   32'd0));
    send_request(mk(REQ_DEFINE,  16'hFFFF, 16'hFFFF,  8'd16,  32'hFFFF_FFFF));
    send_request(mk(REQ_DEFINE,  16'h1234, 16'd0,     8'd255, 32'd0));
    send_request(mk(REQ_DEFINE,  16'h1234, 16'd0,     8'd17,  32'd0));
    send_request(mk(REQ_DEFINE,  16'h1234, 16'd0,     8'd5,   32'd0));
    send_request(mk(REQ_ENABLE,  16'h0000, 16'hFFFF,  8'hFF,  32'hFFFF_FFFF));
    send_request(mk(REQ_ENABLE,  16'hFFFF, 16'd0,     8'd0,   32'd0));
    send_request(mk(REQ_ENABLE,  16'h1234, 16'd0,     8'd0,   32'd0));
    send_request(mk(REQ_ENABLE,  16'h5555, 16'd0,     8'd0,   32'd0));
    // last time zero, elapsed zero: nothing due
    send_request(mk(REQ_TICK,    16'h0000, 16'd0,     8'd0,   32'd0));
    send_request(mk(REQ_TICK,    16'hFFFF, 16'hFFFF,  8'hFF,  32'd1));
    send_request(mk(REQ_REPORT,  16'hFFFF, 16'd0,     8'd0,   32'd0));
    send_request(mk(REQ_REPORT,  16'hAAAA, 16'd0,     8'd0,   32'd0));
    // two entries due at once, last set on the second
    send_request(mk(REQ_TICK,    16'h0000, 16'd0,     8'd0,   32'hFFFF_FFFF));
    // redefining an id disables it again
    send_request(mk(REQ_DEFINE,  16'h0000, 16'd2,     8'd1,   32'd0));
    send_request(mk(REQ_TICK,    16'h0000, 16'd0,     8'd0,   32'h0000_0010));
    send_request(mk(REQ_DISABLE, 16'hFFFF, 16'd0,     8'd0,   32'd0));
    send_request(mk(REQ_DISABLE, 16'h7777, 16'd0,     8'd0,   32'd0));
    send_request(mk(REQ_RSVD_6,  16'h00FF, 16'd3,     8'd0,   32'd0));
    send_request(mk(REQ_RSVD_7,  16'hFF00, 16'd0,     8'd200, 32'd0));
    send_request(mk(REQ_DELETE,  16'h1234, 16'd0,     8'd0,   32'd0));
    send_request(mk(REQ_DELETE,  16'h1234, 16'd0,     8'd0,   32'd0));
    send_request(mk(REQ_TICK,    16'h0000, 16'd0,     8'd0,   32'h8000_0000));

    // Random traffic; clock starts near the wrap point
    now_clock = 32'hFFFF_F000;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 90) hold_asks <= hold_asks + 1;
      if (n == 170) wait_drained();
      send_request(draw_request());
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[periodic_report_scheduler_table] OK");
    end else begin
      $display("%0d errors, %0d results outstanding", sb.errors, sb.pending());
      $display("[periodic_report_scheduler_table] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/prst_pkg.sv
design/prst_if.sv
design/prst_ram.sv
design/prst_eval.sv
design/periodic_report_scheduler_table.sv
dv/periodic_report_scheduler_table_tb.sv
